@@ src/lut_power_approximation_core_assert.svh @@
// Assertion macros used by the checker file of the power approximation core.
`ifndef LUT_POWER_APPROXIMATION_CORE_ASSERT_SVH
`define LUT_POWER_APPROXIMATION_CORE_ASSERT_SVH

// Assertion with an explicit clock and an active-low reset.
`define LPA_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lpa assertion failed");

// Assertion on the default clock and reset names.
`define LPA_ASSERT(label, prop) \
  `LPA_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

@@ src/lpa_pkg.sv @@
// Shared types, widths and octave tables of the power approximation core.
`default_nettype none

package lpa_pkg;

  localparam int unsigned MAG_W = 30;
  localparam int unsigned RES_W = 29;
  localparam int unsigned IDX_W = 5;
  localparam int unsigned ROWS  = 32;

  typedef enum logic [0:0] {
    OP_EXP95 = 1'b0,
    OP_EXP80 = 1'b1
  } opcode_e;

  localparam logic [RES_W-1:0] RES_MAX = 29'd379625056;

  // Row k holds about (2^(k-1))^0.95.
  localparam logic [RES_W-1:0] EXP95_ROWS [ROWS] = '{
    29'd0, 29'd1, 29'd1, 29'd3, 29'd7, 29'd13, 29'd26, 29'd51,
    29'd100, 29'd194, 29'd374, 29'd724, 29'd1398, 29'd2702, 29'd5220, 29'd10085,
    29'd19483, 29'd37640, 29'd72716, 29'd140479, 29'd271388, 29'd524288,
    29'd1012857, 29'd1956712, 29'd3780118, 29'd7302707, 29'd14107901,
    29'd27254668, 29'd52652548, 29'd101718016, 29'd196506256, 29'd379625056
  };

  // Row k holds about (2^(k-1))^0.80.
  localparam logic [RES_W-1:0] EXP80_ROWS [ROWS] = '{
    29'd0, 29'd1, 29'd1, 29'd3, 29'd5, 29'd9, 29'd16, 29'd27,
    29'd48, 29'd84, 29'd147, 29'd256, 29'd445, 29'd776, 29'd1351, 29'd2352,
    29'd4096, 29'd7131, 29'd12416, 29'd21618, 29'd37640, 29'd65536,
    29'd114104, 29'd198668, 29'd345901, 29'd602248, 29'd1048576,
    29'd1825676, 29'd3178688, 29'd5534417, 29'd9635980, 29'd16777216
  };

endpackage

`default_nettype wire

@@ src/lpa_if.sv @@
// Valid/ready channel interfaces for the input and result items.
`default_nettype none

interface lpa_in_if import lpa_pkg::*; ();
  logic             valid;
  logic             ready;
  opcode_e          opcode;
  logic [MAG_W-1:0] magnitude;

  modport source (output valid, output opcode, output magnitude, input ready);
  modport sink   (input valid, input opcode, input magnitude, output ready);
endinterface

interface lpa_out_if import lpa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

`default_nettype wire

@@ src/lut_power_approximation_core.sv @@
// Top level of the piecewise-linear power approximation core.
//
//   Channel  Dir  Handshake     Payload
//   in_i     in   valid/ready   opcode (1 bit), magnitude (30 bits)
//   out_o    out  valid/ready   power_result (29 bits)
//
// One item enters per clock unless a stalled result backs up to the input.
// The pipeline has four register stages: input capture, table lookup, multiply
// and blend; the single 29 by 29 multiplier sets the stage length.
// Each stage loads when it is empty or its successor loads, so a stalled result
// holds its stage while bubbles further up still fill.
// Reset clears only the stage valid flags; payload registers are not reset.
`default_nettype none

module lut_power_approximation_core import lpa_pkg::*; #(
  parameter int unsigned INPUT_BITS = 30
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpa_in_if.sink     in_i,
  lpa_out_if.source  out_o
);

  localparam int unsigned WGT_W  = INPUT_BITS - 1;
  localparam int unsigned PROD_W = RES_W + WGT_W;

  // Stage enables, computed from the result end backwards.
  logic ld0, ld1, ld2, ld3;

  // Stage 0: captured input item.
  logic                  v0_q;
  opcode_e               op0_q;
  logic [INPUT_BITS-1:0] mag0_q;

  // Stage 1: lower row, row step, weight and shift amount.
  logic             v1_q;
  logic [RES_W-1:0] lo1_q,  lo1_d;
  logic [RES_W-1:0] dl1_q,  dl1_d;
  logic [WGT_W-1:0] w1_q,   w1_d;
  logic [IDX_W-1:0] sh1_q,  sh1_d;

  // Stage 2: product of the row step and the weight.
  logic              v2_q;
  logic [RES_W-1:0]  lo2_q;
  logic [PROD_W-1:0] prod2_q, prod2_d;
  logic [IDX_W-1:0]  sh2_q;

  // Stage 3: finished result waiting for the sink.
  logic             v3_q;
  logic [RES_W-1:0] res3_q, res3_d;

  assign ld3 = !v3_q || out_o.ready;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;
  assign ld0 = !v0_q || ld1;

  assign in_i.ready         = ld0;
  assign out_o.valid        = v3_q;
  assign out_o.power_result = res3_q;

  lpa_seg_select #(
    .INPUT_BITS (INPUT_BITS)
  ) u_seg_select (
    .opcode_i    (op0_q),
    .magnitude_i (mag0_q),
    .lo_o        (lo1_d),
    .delta_o     (dl1_d),
    .weight_o    (w1_d),
    .shift_o     (sh1_d)
  );

  // Interpolation: result = lo + ((hi - lo) * weight >> (msb - 1)).
  assign prod2_d = PROD_W'(dl1_q) * PROD_W'(w1_q);

  lpa_blend #(
    .INPUT_BITS (INPUT_BITS)
  ) u_blend (
    .lo_i     (lo2_q),
    .prod_i   (prod2_q),
    .shift_i  (sh2_q),
    .result_o (res3_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ld0) v0_q <= in_i.valid;
      if (ld1) v1_q <= v0_q;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld0) begin
      op0_q  <= in_i.opcode;
      mag0_q <= in_i.magnitude[INPUT_BITS-1:0];
    end
    if (ld1) begin
      lo1_q <= lo1_d;
      dl1_q <= dl1_d;
      w1_q  <= w1_d;
      sh1_q <= sh1_d;
    end
    if (ld2) begin
      lo2_q   <= lo1_q;
      prod2_q <= prod2_d;
      sh2_q   <= sh1_q;
    end
    if (ld3) begin
      res3_q <= res3_d;
    end
  end

endmodule

`default_nettype wire

@@ src/lpa_seg_select.sv @@
// Top-bit search and octave table lookup for one magnitude.
`default_nettype none

module lpa_seg_select import lpa_pkg::*; #(
  parameter int unsigned INPUT_BITS = 30
) (
  input  opcode_e                 opcode_i,
  input  logic [INPUT_BITS-1:0]   magnitude_i,
  output logic [RES_W-1:0]        lo_o,
  output logic [RES_W-1:0]        delta_o,
  output logic [INPUT_BITS-2:0]   weight_o,
  output logic [IDX_W-1:0]        shift_o
);

  logic [IDX_W-1:0] msb;
  logic [IDX_W-1:0] msb_next;
  logic [RES_W-1:0] hi;

  // One-based position of the highest set bit, zero for a zero magnitude.
  always_comb begin
    msb = '0;
    for (int i = 0; i < INPUT_BITS; i++) begin
      if (magnitude_i[i]) begin
        msb = IDX_W'(i + 1);
      end
    end
  end

  assign msb_next = msb + IDX_W'(1);
  assign shift_o  = (msb == '0) ? '0 : msb - IDX_W'(1);

  // The bits below the top bit form the interpolation weight.
  always_comb begin
    for (int i = 0; i < INPUT_BITS - 1; i++) begin
      weight_o[i] = magnitude_i[i] && (IDX_W'(i) < shift_o);
    end
  end

  always_comb begin
    if (opcode_i == OP_EXP80) begin
      lo_o = EXP80_ROWS[msb];
      hi   = EXP80_ROWS[msb_next];
    end else begin
      lo_o = EXP95_ROWS[msb];
      hi   = EXP95_ROWS[msb_next];
    end
  end

  // Tables rise monotonically, so the step between rows is never negative.
  assign delta_o = hi - lo_o;

endmodule

`default_nettype wire

@@ src/lpa_blend.sv @@
// Scales the interpolation product back down and adds the lower table row.
`default_nettype none

module lpa_blend import lpa_pkg::*; #(
  parameter int unsigned INPUT_BITS = 30
) (
  input  logic [RES_W-1:0]            lo_i,
  input  logic [RES_W+INPUT_BITS-2:0] prod_i,
  input  logic [IDX_W-1:0]            shift_i,
  output logic [RES_W-1:0]            result_o
);

  logic [RES_W+INPUT_BITS-2:0] scaled;

  // The lower row shifted up has no bits below the shift, so adding it after
  // the shift gives the same value as shifting the full weighted sum.
  assign scaled   = prod_i >> shift_i;
  assign result_o = lo_i + scaled[RES_W-1:0];

endmodule

`default_nettype wire

@@ src/lpa_checker.sv @@
// Port-level checks of the power approximation core, bound to its top level.
`default_nettype none
`include "lut_power_approximation_core_assert.svh"

module lpa_checker import lpa_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [RES_W-1:0] power_result_i
);

  localparam logic [2:0] DEPTH = 3'd4;

  logic       in_fire;
  logic       out_fire;
  logic [2:0] pending_q;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // Items taken in but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(in_fire) - 3'(out_fire);
    end
  end

  `LPA_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(power_result_i))
  `LPA_ASSERT(a_pending_bound, pending_q <= DEPTH)
  `LPA_ASSERT(a_no_spurious_out, out_valid_i |-> pending_q != 3'd0)
  `LPA_ASSERT(a_ready_when_drained, out_ready_i |-> in_ready_i)
  `LPA_ASSERT(a_result_range, out_valid_i |-> power_result_i <= RES_MAX)

endmodule

bind lut_power_approximation_core lpa_checker u_lpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .power_result_i (out_o.power_result)
);

`default_nettype wire
